/* rtl/rmef_pkg.sv */
`timescale 1ns / 1ps
package rmef_pkg;

	localparam int CHANNELS  = 4;
	localparam int WINDOW    = 5;
	localparam int FRAC_BITS = 8;

	localparam int CH_W      = 2;
	localparam int SMP_W     = 12;
	localparam int EMA_W     = 20;
	localparam int ALPHA_W   = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 12;

	localparam int ALPHA_SHIFT = 8;
	localparam int ALPHA_ONE   = 1 << ALPHA_SHIFT;

	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	localparam int TGT_W  = SMP_W + FRAC_BITS;
	localparam int CALC_W = ((TGT_W > EMA_W) ? TGT_W : EMA_W) + 2;
	localparam int PROD_W = CALC_W + ALPHA_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA      = 3'd0,
		REG_LOW_LIMIT  = 3'd1,
		REG_HIGH_LIMIT = 3'd2,
		REG_FAULT_A    = 3'd3,
		REG_FAULT_B    = 3'd4
	} rmef_reg_t;

	typedef struct packed {
		logic        [ALPHA_W-1:0] alpha;
		logic signed [SMP_W-1:0]   low_limit;
		logic signed [SMP_W-1:0]   high_limit;
		logic signed [SMP_W-1:0]   fault_code_a;
		logic signed [SMP_W-1:0]   fault_code_b;
	} rmef_cfg_t;

	typedef logic signed [SMP_W-1:0] rmef_row_t [WINDOW];

endpackage

/* rtl/rmef_cfg_regs.sv */
`timescale 1ns / 1ps
module rmef_cfg_regs
	import rmef_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output rmef_cfg_t            cfg
);

	rmef_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha        <= ALPHA_W'(77);
			cfg_q.low_limit    <= -SMP_W'(640);
			cfg_q.high_limit   <= SMP_W'(2000);
			cfg_q.fault_code_a <= -SMP_W'(2032);
			cfg_q.fault_code_b <= SMP_W'(1360);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA:      cfg_q.alpha        <= cfg_data[ALPHA_W-1:0];
				REG_LOW_LIMIT:  cfg_q.low_limit    <= cfg_data[SMP_W-1:0];
				REG_HIGH_LIMIT: cfg_q.high_limit   <= cfg_data[SMP_W-1:0];
				REG_FAULT_A:    cfg_q.fault_code_a <= cfg_data[SMP_W-1:0];
				REG_FAULT_B:    cfg_q.fault_code_b <= cfg_data[SMP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/rmef_median.sv */
`timescale 1ns / 1ps
module rmef_median
	import rmef_pkg::*;
(
	input  rmef_row_t               row,
	input  logic [CNT_W-1:0]        count,
	output logic signed [SMP_W-1:0] median
);

	// Each filled entry gets a stable rank; the entry whose rank is count/2 is the median.
	logic [CNT_W-1:0] rank [WINDOW];
	logic [CNT_W-1:0] mid;

	assign mid = count >> 1;

	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if ((CNT_W'(j) < count) &&
				    ((row[j] < row[i]) || ((row[j] == row[i]) && (j < i)))) begin
					rank[i] = rank[i] + CNT_W'(1);
				end
			end
		end
	end

	always_comb begin
		median = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if ((CNT_W'(i) < count) && (rank[i] == mid)) begin
				median = median | row[i];
			end
		end
	end

endmodule

/* rtl/rmef_ema.sv */
`timescale 1ns / 1ps
module rmef_ema
	import rmef_pkg::*;
(
	input  logic signed [SMP_W-1:0] median,
	input  logic signed [EMA_W-1:0] ema,
	input  logic                    has_value,
	input  logic [ALPHA_W-1:0]      alpha,
	output logic signed [EMA_W-1:0] ema_next
);

	logic signed [CALC_W-1:0]  target;
	logic signed [CALC_W-1:0]  ema_ext;
	logic signed [CALC_W-1:0]  diff;
	logic signed [ALPHA_W:0]   weight;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  step;
	logic signed [CALC_W-1:0]  sum;
	logic signed [CALC_W-1:0]  pick;
	logic                      ovf;

	assign target  = CALC_W'(signed'({median, {FRAC_BITS{1'b0}}}));
	assign ema_ext = CALC_W'(ema);
	assign diff    = target - ema_ext;
	assign weight  = (alpha > ALPHA_W'(ALPHA_ONE)) ? (ALPHA_W+1)'(ALPHA_ONE)
	                                               : signed'({1'b0, alpha});
	assign prod    = diff * weight;
	assign step    = prod >>> ALPHA_SHIFT;
	assign sum     = ema_ext + step[CALC_W-1:0];
	assign pick    = has_value ? sum : target;

	assign ovf = (pick[CALC_W-1:EMA_W-1] != {(CALC_W-EMA_W+1){pick[CALC_W-1]}});

	always_comb begin
		if (ovf) begin
			ema_next = pick[CALC_W-1] ? {1'b1, {(EMA_W-1){1'b0}}} : {1'b0, {(EMA_W-1){1'b1}}};
		end else begin
			ema_next = pick[EMA_W-1:0];
		end
	end

endmodule

/* rtl/reject_median_ema_filter_unit.sv */
`timescale 1ns / 1ps
// A word accepted into the input register is processed combinationally; its result word is
// written to the output register when the word advances, and result_stall can hold it back.
// Throughput: one word per cycle unless stalled; the per-channel state is read and rewritten as the word advances.
// Reset clears configuration to its defaults and every channel's count, position and average.
// Sample history has no reset; only entries already written are ever used.
module reject_median_ema_filter_unit
	import rmef_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  logic [CH_W-1:0]         channel,
	input  logic signed [SMP_W-1:0] sample,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [CH_W-1:0]         out_channel,
	output logic signed [EMA_W-1:0] filtered,
	output logic                    valid_res
);

	rmef_cfg_t cfg;

	rmef_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic                    valid_s1;
	logic [CH_W-1:0]         channel_s1;
	logic signed [SMP_W-1:0] sample_s1;

	logic                    result_valid_q;
	logic [CH_W-1:0]         out_channel_q;
	logic signed [EMA_W-1:0] filtered_q;
	logic                    valid_res_q;

	logic signed [SMP_W-1:0] hist_q  [CHANNELS][WINDOW];
	logic [CNT_W-1:0]        fill_q  [CHANNELS];
	logic [POS_W-1:0]        wpos_q  [CHANNELS];
	logic signed [EMA_W-1:0] ema_q   [CHANNELS];
	logic                    has_q   [CHANNELS];

	logic                    advance;
	logic                    accept;
	logic                    present;
	logic                    reject;
	logic                    take;
	logic [CH_W-1:0]         ch;
	logic [POS_W-1:0]        wp_eff;
	logic [POS_W-1:0]        wp_next;
	logic [CNT_W-1:0]        cnt_new;
	rmef_row_t               row;
	logic signed [SMP_W-1:0] median;
	logic signed [EMA_W-1:0] ema_next;
	logic                    res_has;
	logic signed [EMA_W-1:0] res_value;

	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;

	assign ch      = channel_s1;
	assign present = ({1'b0, ch} < (CH_W+1)'(CHANNELS));
	assign reject  = (sample_s1 == cfg.fault_code_a) || (sample_s1 == cfg.fault_code_b) ||
	                 (sample_s1 < cfg.low_limit) || (sample_s1 > cfg.high_limit);
	assign take    = present && !reject;

	assign wp_eff  = (wpos_q[ch] >= POS_W'(WINDOW)) ? '0 : wpos_q[ch];
	assign wp_next = (wp_eff == POS_W'(WINDOW - 1)) ? '0 : wp_eff + POS_W'(1);
	assign cnt_new = (fill_q[ch] < CNT_W'(WINDOW)) ? fill_q[ch] + CNT_W'(1) : fill_q[ch];

	always_comb begin
		for (int k = 0; k < WINDOW; k++) begin
			row[k] = (POS_W'(k) == wp_eff) ? sample_s1 : hist_q[ch][k];
		end
	end

	rmef_median u_median (
		.row    (row),
		.count  (cnt_new),
		.median (median)
	);

	rmef_ema u_ema (
		.median    (median),
		.ema       (ema_q[ch]),
		.has_value (has_q[ch]),
		.alpha     (cfg.alpha),
		.ema_next  (ema_next)
	);

	assign res_has   = present && (has_q[ch] || take);
	assign res_value = !res_has ? '0 : (take ? ema_next : ema_q[ch]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			result_valid_q <= advance || (result_valid_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			channel_s1 <= channel;
			sample_s1  <= sample;
		end
		if (advance) begin
			out_channel_q <= ch;
			filtered_q    <= res_value;
			valid_res_q   <= res_has;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				fill_q[c] <= '0;
				wpos_q[c] <= '0;
				ema_q[c]  <= '0;
				has_q[c]  <= 1'b0;
			end
		end else if (advance && take) begin
			fill_q[ch] <= cnt_new;
			wpos_q[ch] <= wp_next;
			ema_q[ch]  <= ema_next;
			has_q[ch]  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && take) begin
			hist_q[ch][wp_eff] <= sample_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign out_channel  = out_channel_q;
	assign filtered     = filtered_q;
	assign valid_res    = valid_res_q;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import rmef_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SHOWN_ERRORS = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_FAULT_B + 1);
	localparam longint AVG_MAX = (longint'(1) << (EMA_W - 1)) - 1;
	localparam longint AVG_MIN = -(longint'(1) << (EMA_W - 1));

	typedef struct {
		logic [CH_W-1:0]         ch;
		logic signed [SMP_W-1:0] smp;
	} sample_word_t;

	typedef struct packed {
		logic [CH_W-1:0]         ch;
		logic signed [EMA_W-1:0] value;
		logic                    has;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [CH_W-1:0] channel = '0;
	logic signed [SMP_W-1:0] sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [CH_W-1:0] out_channel;
	logic signed [EMA_W-1:0] filtered;
	logic valid_res;

	reject_median_ema_filter_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.channel(channel),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_channel(out_channel),
		.filtered(filtered),
		.valid_res(valid_res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow of the filter: configuration and per-channel state.
	logic [ALPHA_W-1:0]      cur_alpha;
	logic signed [SMP_W-1:0] cur_lo;
	logic signed [SMP_W-1:0] cur_hi;
	logic signed [SMP_W-1:0] cur_fault_a;
	logic signed [SMP_W-1:0] cur_fault_b;
	logic signed [SMP_W-1:0] ring_mem [CHANNELS][WINDOW];
	int                      ring_fill [CHANNELS];
	int                      ring_pos [CHANNELS];
	logic signed [EMA_W-1:0] avg_val [CHANNELS];
	logic                    avg_ok [CHANNELS];

	sample_word_t feed_q[$];
	reading_t     avg_expect_q[$];
	int items_issued = 0;
	int results_seen = 0;
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int out_stall_pct = 0;
	logic in_taken = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	function automatic reading_t filter_step(input logic [CH_W-1:0] ch,
			input logic signed [SMP_W-1:0] s);
		reading_t r;
		int srt [WINDOW];
		int n, m, key, i, j;
		longint tgt, wgt, nxt;
		r.ch = ch;
		r.value = '0;
		r.has = 1'b0;
		if (!(s == cur_fault_a || s == cur_fault_b || s < cur_lo || s > cur_hi)) begin
			ring_mem[ch][ring_pos[ch]] = s;
			if (ring_fill[ch] < WINDOW)
				ring_fill[ch]++;
			ring_pos[ch] = (ring_pos[ch] + 1) % WINDOW;
			n = ring_fill[ch];
			for (i = 0; i < n; i++)
				srt[i] = ring_mem[ch][i];
			for (i = 1; i < n; i++) begin
				key = srt[i];
				j = i;
				while (j > 0 && srt[j - 1] > key) begin
					srt[j] = srt[j - 1];
					j--;
				end
				srt[j] = key;
			end
			m = srt[n / 2];
			tgt = longint'(m) * (longint'(1) << FRAC_BITS);
			if (!avg_ok[ch]) begin
				nxt = tgt;
				avg_ok[ch] = 1'b1;
			end else begin
				wgt = (cur_alpha > ALPHA_ONE) ? ALPHA_ONE : longint'(cur_alpha);
				nxt = longint'(avg_val[ch]);
				nxt = nxt + ((wgt * (tgt - nxt)) >>> ALPHA_SHIFT);
			end
			if (nxt > AVG_MAX)
				nxt = AVG_MAX;
			else if (nxt < AVG_MIN)
				nxt = AVG_MIN;
			avg_val[ch] = EMA_W'(nxt);
		end
		if (avg_ok[ch]) begin
			r.value = avg_val[ch];
			r.has = 1'b1;
		end
		return r;
	endfunction

	function automatic logic signed [SMP_W-1:0] pick_sample();
		int pick, lo, hi;
		lo = cur_lo;
		hi = cur_hi;
		pick = $urandom_range(0, 99);
		if (pick < 70 && lo <= hi)
			return SMP_W'(lo + int'($urandom_range(0, hi - lo)));
		if (pick < 78)
			return pick[0] ? cur_fault_a : cur_fault_b;
		if (pick < 90) begin
			case ($urandom_range(0, 3))
				0: return SMP_W'(lo - 1);
				1: return SMP_W'(lo);
				2: return SMP_W'(hi);
				default: return SMP_W'(hi + 1);
			endcase
		end
		return SMP_W'($urandom);
	endfunction

	task automatic note_error(input string msg);
		errors++;
		if (errors <= SHOWN_ERRORS)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic add_item(input int ch, input logic signed [SMP_W-1:0] s);
		sample_word_t w;
		w.ch = CH_W'(ch);
		w.smp = s;
		feed_q.push_back(w);
		items_issued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_alpha(input int val);
		logic [CFG_W-1:0] d;
		d = CFG_W'($urandom);
		d[ALPHA_W-1:0] = ALPHA_W'(val);
		write_reg(REG_ALPHA, d);
	endtask

	task automatic settle();
		wait (results_seen == items_issued);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
		@(posedge clk);
		send_idle_pct = idle_pct;
		out_stall_pct = stall_pct;
		repeat (n)
			add_item($urandom_range(0, CHANNELS - 1), pick_sample());
		settle();
	endtask

	always @(negedge clk) begin
		sample_word_t w;
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (in_taken || !sample_valid) begin
			if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				w = feed_q.pop_front();
				channel <= w.ch;
				sample <= w.smp;
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(negedge clk)
		result_stall <= (hold_left != 0) || ($urandom_range(0, 99) < out_stall_pct);

	always @(posedge clk) begin
		reading_t got, want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= sample_valid && sample_stall === 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_ALPHA:      cur_alpha = cfg_data[ALPHA_W-1:0];
					REG_LOW_LIMIT:  cur_lo = cfg_data[SMP_W-1:0];
					REG_HIGH_LIMIT: cur_hi = cfg_data[SMP_W-1:0];
					REG_FAULT_A:    cur_fault_a = cfg_data[SMP_W-1:0];
					REG_FAULT_B:    cur_fault_b = cfg_data[SMP_W-1:0];
					default: ;
				endcase
			end
			if (result_valid === 1'b1 && !result_stall) begin
				results_seen++;
				got.ch = out_channel;
				got.value = filtered;
				got.has = valid_res;
				if (avg_expect_q.size() == 0) begin
					note_error($sformatf("unexpected word: ch %0d filtered %0d valid %b",
						got.ch, got.value, got.has));
				end else begin
					want = avg_expect_q.pop_front();
					if (got !== want)
						note_error($sformatf({"mismatch: ch exp %0d got %0d, filtered exp %0d ",
							"got %0d, valid exp %b got %b"}, want.ch, got.ch, want.value,
							got.value, want.has, got.has));
				end
			end
			if (sample_valid && sample_stall === 1'b0)
				avg_expect_q.push_back(filter_step(channel, sample));
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("** reject_median_ema_filter_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		int lo, hi;
		cur_alpha = 77;
		cur_lo = -640;
		cur_hi = 2000;
		cur_fault_a = -2032;
		cur_fault_b = 1360;
		for (int c = 0; c < CHANNELS; c++) begin
			ring_fill[c] = 0;
			ring_pos[c] = 0;
			avg_val[c] = '0;
			avg_ok[c] = 1'b0;
			for (int k = 0; k < WINDOW; k++)
				ring_mem[c][k] = '0;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rejections before a channel has a value, limit edges, fault codes,
		// even fill counts and ring wraparound.
		add_item(3, -2032);
		add_item(3, -2048);
		add_item(0, 2047);
		add_item(0, -640);
		add_item(0, -641);
		add_item(0, 2000);
		add_item(0, 2001);
		add_item(0, 1360);
		add_item(0, 0);
		add_item(0, 100);
		add_item(0, -5);
		add_item(0, 7);
		add_item(0, 8);
		add_item(1, 1);
		add_item(1, 2);
		add_item(1, 3);
		add_item(1, 4);
		add_item(2, 0);
		add_item(2, 2047);
		add_item(2, -1);
		add_item(3, 1999);
		add_item(3, -2032);
		settle();

		run_phase(200, 0, 0);

		set_alpha(ALPHA_ONE);
		write_reg(REG_LOW_LIMIT, CFG_W'(-2048));
		write_reg(REG_HIGH_LIMIT, CFG_W'(2047));
		write_reg(REG_FAULT_A, CFG_W'($urandom));
		write_reg(REG_FAULT_B, CFG_W'($urandom));
		add_item(1, -2048);
		add_item(2, 2047);
		run_phase(200, 50, 0);

		set_alpha(0);
		write_reg(REG_LOW_LIMIT, CFG_W'(-100));
		write_reg(REG_HIGH_LIMIT, CFG_W'(100));
		write_reg(REG_FAULT_A, CFG_W'(-2048));
		write_reg(REG_FAULT_B, CFG_W'(2047));
		run_phase(200, 0, 50);

		lo = -int'($urandom_range(0, 2048));
		hi = $urandom_range(0, 2047);
		set_alpha((1 << ALPHA_W) - 1);
		write_reg(REG_LOW_LIMIT, CFG_W'(lo));
		write_reg(REG_HIGH_LIMIT, CFG_W'(hi));
		write_reg(REG_FAULT_A, CFG_W'(lo + int'($urandom_range(0, hi - lo))));
		write_reg(REG_FAULT_B, CFG_W'(lo + int'($urandom_range(0, hi - lo))));
		write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(0, 2)), CFG_W'($urandom));
		run_phase(200, 16, 16);

		// Crossed limits reject everything.
		set_alpha(300);
		write_reg(REG_LOW_LIMIT, CFG_W'(500));
		write_reg(REG_HIGH_LIMIT, CFG_W'(-500));
		run_phase(60, 16, 16);

		set_alpha(1);
		write_reg(REG_LOW_LIMIT, CFG_W'(-640));
		write_reg(REG_HIGH_LIMIT, CFG_W'(2000));
		write_reg(REG_FAULT_A, CFG_W'(-2032));
		write_reg(REG_FAULT_B, CFG_W'(1360));
		@(posedge clk);
		hold_req = 1'b1;
		run_phase(200, 0, 0);

		set_alpha($urandom_range(2, ALPHA_ONE - 1));
		run_phase(60, 16, 16);

		repeat (10) @(negedge clk);
		if (avg_expect_q.size() != 0)
			note_error($sformatf("%0d expected words never arrived", avg_expect_q.size()));
		if (errors == 0)
			$display("** reject_median_ema_filter_unit: PASSED **");
		else
			$display("** reject_median_ema_filter_unit: FAILED **");
		$finish;
	end

endmodule
